// ===== src/tls_client_hello_sni_extractor_defines.svh =====
// ----------------------------------------------------------------------------
// TLS ClientHello SNI extractor: assertion macros
// Shared checking macros for the server name extractor.
// ----------------------------------------------------------------------------
`ifndef TLS_CLIENT_HELLO_SNI_EXTRACTOR_DEFINES_SVH
`define TLS_CLIENT_HELLO_SNI_EXTRACTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLSSNI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TLSSNI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/tlssni_pkg.sv =====
// ----------------------------------------------------------------------------
// TLS ClientHello SNI extractor package
// Parse phase codes, TLS byte values and the result item type.
// ----------------------------------------------------------------------------
package tlssni_pkg;

    // Parse phases.
    localparam logic [3:0] PH_REC     = 4'd0;
    localparam logic [3:0] PH_HSTYPE  = 4'd1;
    localparam logic [3:0] PH_SIDLEN  = 4'd2;
    localparam logic [3:0] PH_CS_HI   = 4'd3;
    localparam logic [3:0] PH_CS_LO   = 4'd4;
    localparam logic [3:0] PH_CM_LEN  = 4'd5;
    localparam logic [3:0] PH_EXT_HI  = 4'd6;
    localparam logic [3:0] PH_EXT_LO  = 4'd7;
    localparam logic [3:0] PH_TYPE_HI = 4'd8;
    localparam logic [3:0] PH_TYPE_LO = 4'd9;
    localparam logic [3:0] PH_NLEN_HI = 4'd10;
    localparam logic [3:0] PH_NLEN_LO = 4'd11;
    localparam logic [3:0] PH_NAME    = 4'd12;
    localparam logic [3:0] PH_IDLE    = 4'd13;

    // Record content types and handshake type.
    localparam logic [7:0] CT_HANDSHAKE     = 8'h16;
    localparam logic [7:0] CT_CHANGE_CIPHER = 8'h14;
    localparam logic [7:0] CT_APP_DATA      = 8'h17;
    localparam logic [7:0] HS_CLIENT_HELLO  = 8'h01;

    // Fixed byte positions and the gap before the server name length.
    localparam logic [15:0] HSTYPE_INDEX = 16'd5;
    localparam logic [15:0] SIDLEN_INDEX = 16'd43;
    localparam logic [15:0] SNI_GAP      = 16'd5;
    localparam logic [15:0] INDEX_SAT    = 16'hFFFF;

    // Record kind codes.
    localparam logic [1:0] RK_HANDSHAKE     = 2'd0;
    localparam logic [1:0] RK_CHANGE_CIPHER = 2'd1;
    localparam logic [1:0] RK_APP_DATA      = 2'd2;
    localparam logic [1:0] RK_NOT_TLS       = 2'd3;

    // Result kind codes.
    localparam logic RES_NAME_CHAR = 1'b0;
    localparam logic RES_VERDICT   = 1'b1;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] name_char;
        logic [1:0] record_kind;
        logic       is_client_hello;
        logic       name_found;
        logic       name_complete;
        logic       last_result;
    } t_result;

endpackage

// ===== src/tls_client_hello_sni_extractor.sv =====
// An accepted byte's results are written to the result queue behind any older results.
// The parser takes one byte per cycle while the result queue has room.
// The final byte of a buffer that is also a name byte yields two results; a four-entry result
// queue drains one per cycle with i_out_ready high; input is taken while two slots are free.
// Reset (synchronous, active low) returns the parser to the record type phase
// and empties the result queue; the parser also resets itself after each buffer.
// ----------------------------------------------------------------------------
// TLS ClientHello SNI extractor
// Parses a client buffer byte by byte, streams the server name and gives a
// verdict on the record at the end of the buffer.
// ----------------------------------------------------------------------------
`include "tls_client_hello_sni_extractor_defines.svh"

module tls_client_hello_sni_extractor #(
    parameter int MAX_BUFFER_BYTES = 32768
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_buffer,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_result_kind,
    output logic [7:0] o_name_char,
    output logic [1:0] o_record_kind,
    output logic       o_is_client_hello,
    output logic       o_name_found,
    output logic       o_name_complete,
    output logic       o_last_result
);
    import tlssni_pkg::*;

    localparam logic [16:0] MaxBytes = 17'(MAX_BUFFER_BYTES);

    // Parser state.
    logic [3:0]  r_phase;
    logic [15:0] r_byte_index;
    logic [7:0]  r_len_hi;
    logic [15:0] r_skip;
    logic [1:0]  r_seen_rk;
    logic        r_seen_ch;
    logic        r_seen_sn;

    logic [3:0]  n_phase;
    logic [15:0] n_byte_index;
    logic [7:0]  n_len_hi;
    logic [15:0] n_skip;
    logic [1:0]  n_seen_rk;
    logic        n_seen_ch;
    logic        n_seen_sn;

    // Result queue.
    t_result     r_fifo [4];
    logic [1:0]  r_wr_ptr;
    logic [1:0]  r_rd_ptr;
    logic [2:0]  r_count;

    logic        in_acc;
    logic        out_acc;
    logic        parse_en;
    logic        got_char;
    logic [1:0]  push_cnt;
    t_result     res_char;
    t_result     res_verdict;
    t_result     res_first;
    t_result     head;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // Bytes beyond the buffer limit or at the saturated index are not parsed.
    assign parse_en = ({1'b0, r_byte_index} < MaxBytes) && (r_byte_index != INDEX_SAT);

    // One parse step on the incoming byte.
    always_comb begin
        n_phase   = r_phase;
        n_len_hi  = r_len_hi;
        n_skip    = r_skip;
        n_seen_rk = r_seen_rk;
        n_seen_ch = r_seen_ch;
        n_seen_sn = r_seen_sn;
        got_char  = 1'b0;
        if (parse_en) begin
            unique case (r_phase)
                PH_REC: begin
                    if (i_data_byte == CT_HANDSHAKE) begin
                        n_seen_rk = RK_HANDSHAKE;
                        n_phase   = PH_HSTYPE;
                    end else if (i_data_byte == CT_CHANGE_CIPHER) begin
                        n_seen_rk = RK_CHANGE_CIPHER;
                        n_phase   = PH_IDLE;
                    end else if (i_data_byte == CT_APP_DATA) begin
                        n_seen_rk = RK_APP_DATA;
                        n_phase   = PH_IDLE;
                    end else begin
                        n_seen_rk = RK_NOT_TLS;
                        n_phase   = PH_IDLE;
                    end
                end
                PH_HSTYPE: begin
                    if (r_byte_index == HSTYPE_INDEX) begin
                        if (i_data_byte == HS_CLIENT_HELLO) begin
                            n_seen_ch = 1'b1;
                            n_phase   = PH_SIDLEN;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                PH_SIDLEN: begin
                    if (r_byte_index == SIDLEN_INDEX) begin
                        n_skip  = {8'h00, i_data_byte};
                        n_phase = PH_CS_HI;
                    end
                end
                PH_CS_HI, PH_EXT_HI, PH_NLEN_HI: begin
                    if (r_skip != 16'd0) begin
                        n_skip = r_skip - 16'd1;
                    end else begin
                        n_len_hi = i_data_byte;
                        n_phase  = r_phase + 4'd1;
                    end
                end
                PH_CS_LO: begin
                    n_skip  = {r_len_hi, i_data_byte};
                    n_phase = PH_CM_LEN;
                end
                PH_CM_LEN: begin
                    if (r_skip != 16'd0) begin
                        n_skip = r_skip - 16'd1;
                    end else begin
                        n_skip  = {8'h00, i_data_byte};
                        n_phase = PH_EXT_HI;
                    end
                end
                PH_EXT_LO: begin
                    n_phase = PH_TYPE_HI;
                end
                PH_TYPE_HI: begin
                    n_len_hi = i_data_byte;
                    n_phase  = PH_TYPE_LO;
                end
                PH_TYPE_LO: begin
                    if (r_len_hi == 8'h00 && i_data_byte == 8'h00) begin
                        n_skip  = SNI_GAP;
                        n_phase = PH_NLEN_HI;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_NLEN_LO: begin
                    n_skip    = {r_len_hi, i_data_byte};
                    n_seen_sn = 1'b1;
                    n_phase   = ({r_len_hi, i_data_byte} != 16'd0) ? PH_NAME : PH_IDLE;
                end
                PH_NAME: begin
                    got_char = 1'b1;
                    if (r_skip != 16'd0) begin
                        n_skip = r_skip - 16'd1;
                    end
                    if (r_skip <= 16'd1) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
        n_byte_index = (r_byte_index != INDEX_SAT) ? r_byte_index + 16'd1 : r_byte_index;
    end

    // Result items caused by this byte.
    always_comb begin
        res_char.result_kind     = RES_NAME_CHAR;
        res_char.name_char       = i_data_byte;
        res_char.record_kind     = RK_HANDSHAKE;
        res_char.is_client_hello = 1'b0;
        res_char.name_found      = 1'b0;
        res_char.name_complete   = 1'b0;
        res_char.last_result     = !i_end_of_buffer;

        res_verdict.result_kind     = RES_VERDICT;
        res_verdict.name_char       = 8'h00;
        res_verdict.record_kind     = n_seen_rk;
        res_verdict.is_client_hello = n_seen_ch;
        res_verdict.name_found      = n_seen_sn;
        res_verdict.name_complete   = n_seen_sn && (n_phase != PH_NAME);
        res_verdict.last_result     = 1'b1;

        res_first = got_char ? res_char : res_verdict;
        push_cnt  = {1'b0, got_char} + {1'b0, i_end_of_buffer};
    end

    // Parser state registers; the end of a buffer restores the reset state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_REC;
            r_byte_index <= 16'd0;
            r_len_hi     <= 8'h00;
            r_skip       <= 16'd0;
            r_seen_rk    <= RK_NOT_TLS;
            r_seen_ch    <= 1'b0;
            r_seen_sn    <= 1'b0;
        end else if (in_acc) begin
            if (i_end_of_buffer) begin
                r_phase      <= PH_REC;
                r_byte_index <= 16'd0;
                r_len_hi     <= 8'h00;
                r_skip       <= 16'd0;
                r_seen_rk    <= RK_NOT_TLS;
                r_seen_ch    <= 1'b0;
                r_seen_sn    <= 1'b0;
            end else begin
                r_phase      <= n_phase;
                r_byte_index <= n_byte_index;
                r_len_hi     <= n_len_hi;
                r_skip       <= n_skip;
                r_seen_rk    <= n_seen_rk;
                r_seen_ch    <= n_seen_ch;
                r_seen_sn    <= n_seen_sn;
            end
        end
    end

    // Result queue storage.
    always_ff @(posedge i_clk) begin
        if (in_acc && push_cnt != 2'd0) begin
            r_fifo[r_wr_ptr] <= res_first;
        end
        if (in_acc && push_cnt == 2'd2) begin
            r_fifo[r_wr_ptr + 2'd1] <= res_verdict;
        end
    end

    // Result queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            if (in_acc) begin
                r_wr_ptr <= r_wr_ptr + push_cnt;
            end
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + (in_acc ? {1'b0, push_cnt} : 3'd0) - {2'b00, out_acc};
        end
    end

    assign o_in_ready  = (r_count <= 3'd2);
    assign o_out_valid = (r_count != 3'd0);
    assign head        = r_fifo[r_rd_ptr];

    assign o_result_kind     = head.result_kind;
    assign o_name_char       = head.name_char;
    assign o_record_kind     = head.record_kind;
    assign o_is_client_hello = head.is_client_hello;
    assign o_name_found      = head.name_found;
    assign o_name_complete   = head.name_complete;
    assign o_last_result     = head.last_result;

    // Checks on queue level, parser invariants and buffer restart.
    `TLSSNI_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= 3'd4)
    `TLSSNI_ASSERT_SAME(a_name_len_live, i_clk, i_rst_n, r_phase == PH_NAME, r_skip != 16'd0)
    `TLSSNI_ASSERT_SAME(a_hello_seen, i_clk, i_rst_n,
        r_phase >= PH_SIDLEN && r_phase <= PH_NAME, r_seen_ch && r_seen_rk == RK_HANDSHAKE)
    `TLSSNI_ASSERT_SAME(a_verdict_last, i_clk, i_rst_n,
        o_out_valid && o_result_kind == RES_VERDICT, o_last_result)
    `TLSSNI_ASSERT_NEXT(a_buffer_restart, i_clk, i_rst_n, in_acc && i_end_of_buffer,
        r_phase == PH_REC && r_byte_index == 16'd0 && !r_seen_sn)

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLS ClientHello SNI extractor testbench
// Feeds client buffers one byte per item: short directed buffers, a back-pressure case, then
// random ClientHello records of several shapes, some cut short, mixed with noise buffers.
// A scoreboard class predicts every name character and end-of-buffer verdict
// and checks each result item field by field, while both sides of the block
// idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

    import tlssni_pkg::*;

    class sni_scoreboard;

        typedef enum logic [3:0] {
            ST_RECORD, ST_HS_TYPE, ST_SID_LEN, ST_SUITES_HI, ST_SUITES_LO, ST_COMP_LEN,
            ST_EXTS_HI, ST_EXTS_LO, ST_EXT_TYPE_HI, ST_EXT_TYPE_LO, ST_NAME_LEN_HI,
            ST_NAME_LEN_LO, ST_NAME, ST_IGNORE
        } t_parse_state;

        localparam logic [15:0] HELLO_TYPE_POS  = 16'd5;
        localparam logic [15:0] SESSION_LEN_POS = 16'd43;
        localparam logic [15:0] NAME_LEN_GAP    = 16'd5;
        localparam logic [15:0] INDEX_MAX       = 16'hFFFF;

        int unsigned  buffer_limit;
        t_parse_state state;
        logic [15:0]  index;
        logic [7:0]   high_byte;
        logic [15:0]  remaining;
        logic [1:0]   kind;
        logic         hello;
        logic         found;

        t_result      expected_q[$];
        int unsigned  failures;
        int unsigned  name_chars;
        int unsigned  verdicts;
        int unsigned  hello_verdicts;
        int unsigned  found_verdicts;
        int unsigned  complete_verdicts;

        function new(int unsigned limit);
            buffer_limit = limit;
            clear();
        endfunction

        // Parser state at the start of each buffer.
        function void clear();
            state     = ST_RECORD;
            index     = '0;
            high_byte = '0;
            remaining = '0;
            kind      = RK_NOT_TLS;
            hello     = 1'b0;
            found     = 1'b0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= 10) begin
                $display("ERROR at %0t: %s", $realtime, msg);
            end
        endfunction

        static function string describe(t_result r);
            return $sformatf("kind %0d char %02h record %0d hello %0b found %0b complete %0b last %0b",
                             r.result_kind, r.name_char, r.record_kind, r.is_client_hello,
                             r.name_found, r.name_complete, r.last_result);
        endfunction

        // Advance the parser by one accepted byte and queue the results it causes.
        function void note_byte(logic [7:0] b, logic eob);
            t_result item;
            logic    emitted;
            emitted = 1'b0;
            if (index < buffer_limit && index != INDEX_MAX) begin
                case (state)
                    ST_RECORD: begin
                        if (b == CT_HANDSHAKE) begin
                            kind  = RK_HANDSHAKE;
                            state = ST_HS_TYPE;
                        end else begin
                            state = ST_IGNORE;
                            if (b == CT_CHANGE_CIPHER) kind = RK_CHANGE_CIPHER;
                            else if (b == CT_APP_DATA) kind = RK_APP_DATA;
                            else kind = RK_NOT_TLS;
                        end
                    end
                    ST_HS_TYPE: begin
                        if (index == HELLO_TYPE_POS) begin
                            if (b == HS_CLIENT_HELLO) begin
                                hello = 1'b1;
                                state = ST_SID_LEN;
                            end else begin
                                state = ST_IGNORE;
                            end
                        end
                    end
                    ST_SID_LEN: begin
                        if (index == SESSION_LEN_POS) begin
                            remaining = {8'h00, b};
                            state     = ST_SUITES_HI;
                        end
                    end
                    ST_SUITES_HI: begin
                        if (remaining != 0) begin
                            remaining--;
                        end else begin
                            high_byte = b;
                            state     = ST_SUITES_LO;
                        end
                    end
                    ST_SUITES_LO: begin
                        remaining = {high_byte, b};
                        state     = ST_COMP_LEN;
                    end
                    ST_COMP_LEN: begin
                        if (remaining != 0) begin
                            remaining--;
                        end else begin
                            remaining = {8'h00, b};
                            state     = ST_EXTS_HI;
                        end
                    end
                    ST_EXTS_HI: begin
                        if (remaining != 0) begin
                            remaining--;
                        end else begin
                            high_byte = b;
                            state     = ST_EXTS_LO;
                        end
                    end
                    ST_EXTS_LO: begin
                        state = ST_EXT_TYPE_HI;
                    end
                    ST_EXT_TYPE_HI: begin
                        high_byte = b;
                        state     = ST_EXT_TYPE_LO;
                    end
                    ST_EXT_TYPE_LO: begin
                        // Only a server name extension in first place is followed.
                        if (high_byte == 8'h00 && b == 8'h00) begin
                            remaining = NAME_LEN_GAP;
                            state     = ST_NAME_LEN_HI;
                        end else begin
                            state = ST_IGNORE;
                        end
                    end
                    ST_NAME_LEN_HI: begin
                        if (remaining != 0) begin
                            remaining--;
                        end else begin
                            high_byte = b;
                            state     = ST_NAME_LEN_LO;
                        end
                    end
                    ST_NAME_LEN_LO: begin
                        remaining = {high_byte, b};
                        found     = 1'b1;
                        state     = (remaining != 0) ? ST_NAME : ST_IGNORE;
                    end
                    ST_NAME: begin
                        emitted = 1'b1;
                        if (remaining != 0) remaining--;
                        if (remaining == 0) state = ST_IGNORE;
                    end
                    default: ;
                endcase
            end
            if (index != INDEX_MAX) index++;

            if (emitted) begin
                item = '{result_kind: RES_NAME_CHAR, name_char: b, record_kind: '0,
                         is_client_hello: 1'b0, name_found: 1'b0, name_complete: 1'b0,
                         last_result: !eob};
                expected_q.push_back(item);
                name_chars++;
            end
            if (eob) begin
                item = '{result_kind: RES_VERDICT, name_char: 8'h00, record_kind: kind,
                         is_client_hello: hello, name_found: found,
                         name_complete: found && state != ST_NAME, last_result: 1'b1};
                expected_q.push_back(item);
                verdicts++;
                if (hello) hello_verdicts++;
                if (found) found_verdicts++;
                if (item.name_complete) complete_verdicts++;
                clear();
            end
        endfunction

        // Compare one accepted result item with the oldest expectation.
        function void check_result(t_result got);
            t_result want;
            string   diff;
            if (expected_q.size() == 0) begin
                report({"result with nothing expected: ", describe(got)});
                return;
            end
            want = expected_q.pop_front();
            diff = "";
            if (got.result_kind !== want.result_kind) diff = {diff, " result_kind"};
            if (got.name_char !== want.name_char) diff = {diff, " name_char"};
            if (got.record_kind !== want.record_kind) diff = {diff, " record_kind"};
            if (got.is_client_hello !== want.is_client_hello) diff = {diff, " is_client_hello"};
            if (got.name_found !== want.name_found) diff = {diff, " name_found"};
            if (got.name_complete !== want.name_complete) diff = {diff, " name_complete"};
            if (got.last_result !== want.last_result) diff = {diff, " last_result"};
            if (diff != "") begin
                report({"mismatch in", diff, "\n  expected ", describe(want),
                        "\n  actual   ", describe(got)});
            end
        endfunction

    endclass

    localparam int unsigned BUFFER_LIMIT    = 32768;
    localparam int unsigned RANDOM_ITEMS    = 1000;
    localparam int unsigned MIN_VERDICTS    = 20;
    localparam int unsigned NUM_SHAPES      = 7;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES    = 16;
    localparam int unsigned HELLO_HEADER    = 58;

    logic       i_clk             = 1'b0;
    logic       i_rst_n           = 1'b0;
    logic       i_in_valid        = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_data_byte       = 8'h00;
    logic       i_end_of_buffer   = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready       = 1'b0;
    logic       o_result_kind;
    logic [7:0] o_name_char;
    logic [1:0] o_record_kind;
    logic       o_is_client_hello;
    logic       o_name_found;
    logic       o_name_complete;
    logic       o_last_result;

    sni_scoreboard sb;
    logic [7:0]    buffer_bytes[$];
    logic          steady_flow      = 1'b0;
    logic          hold_off_request = 1'b0;
    int unsigned   bytes_sent       = 0;
    int unsigned   buffers_sent     = 0;

    tls_client_hello_sni_extractor #(
        .MAX_BUFFER_BYTES(BUFFER_LIMIT)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_end_of_buffer  (i_end_of_buffer),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_kind    (o_result_kind),
        .o_name_char      (o_name_char),
        .o_record_kind    (o_record_kind),
        .o_is_client_hello(o_is_client_hello),
        .o_name_found     (o_name_found),
        .o_name_complete  (o_name_complete),
        .o_last_result    (o_last_result)
    );

    // Clock: 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle stretches: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Extension type other than server name, including one zero byte at times.
    function automatic logic [15:0] other_extension();
        case ($urandom_range(0, 2))
            0: return {8'h00, 8'($urandom_range(1, 255))};
            1: return {8'($urandom_range(1, 255)), 8'h00};
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    // Lay out a ClientHello record with random filler in the unchecked fields.
    function automatic void build_hello(int unsigned sid_len, logic [15:0] suites_len,
                                        int unsigned comp_len, logic [15:0] ext_type,
                                        logic [15:0] name_len, int unsigned trailing);
        buffer_bytes.delete();
        buffer_bytes.push_back(CT_HANDSHAKE);
        repeat (4) buffer_bytes.push_back(8'($urandom));
        buffer_bytes.push_back(HS_CLIENT_HELLO);
        // Handshake length, version and client random.
        repeat (37) buffer_bytes.push_back(8'($urandom));
        buffer_bytes.push_back(8'(sid_len));
        repeat (sid_len) buffer_bytes.push_back(8'($urandom));
        buffer_bytes.push_back(suites_len[15:8]);
        buffer_bytes.push_back(suites_len[7:0]);
        repeat (suites_len) buffer_bytes.push_back(8'($urandom));
        buffer_bytes.push_back(8'(comp_len));
        repeat (comp_len) buffer_bytes.push_back(8'($urandom));
        repeat (2) buffer_bytes.push_back(8'($urandom));
        buffer_bytes.push_back(ext_type[15:8]);
        buffer_bytes.push_back(ext_type[7:0]);
        // Extension length, list length and name type.
        repeat (5) buffer_bytes.push_back(8'($urandom));
        buffer_bytes.push_back(name_len[15:8]);
        buffer_bytes.push_back(name_len[7:0]);
        repeat (name_len) buffer_bytes.push_back(8'($urandom));
        repeat (trailing) buffer_bytes.push_back(8'($urandom));
    endfunction

    // Offer one item after an optional gap and hold it until it is taken.
    task automatic send_byte(logic [7:0] value, logic last);
        int unsigned gap;
        gap = steady_flow ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_data_byte     <= value;
        i_end_of_buffer <= last;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
    endtask

    task automatic send_buffer();
        foreach (buffer_bytes[i]) begin
            send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1);
        end
        buffers_sent++;
    endtask

    // Sender stays quiet until every predicted result has been taken.
    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Result side: random ready pattern, steady runs, and one long hold-off on request.
    initial begin : receiver
        logic        level;
        int unsigned left;
        int unsigned gap;
        level = 1'b1;
        left  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                level            = 1'b0;
                left             = HOLD_OFF_CYCLES;
            end else if (left == 0) begin
                if (steady_flow || !level) begin
                    level = 1'b1;
                    left  = steady_flow ? 1 : $urandom_range(1, 24);
                end else begin
                    gap   = pick_gap();
                    level = (gap == 0);
                    left  = (gap == 0) ? 1 : gap;
                end
            end
            left--;
            i_out_ready <= level;
        end
    end

    // Sample both handshakes at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sb.note_byte(i_data_byte, i_end_of_buffer);
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_result('{result_kind: o_result_kind, name_char: o_name_char,
                                  record_kind: o_record_kind,
                                  is_client_hello: o_is_client_hello,
                                  name_found: o_name_found, name_complete: o_name_complete,
                                  last_result: o_last_result});
            end
        end
    end

    // Watchdog on cycles in which no item moves on either side.
    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("ERROR: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        logic [7:0]  single_bytes[5];
        int unsigned random_start;
        int unsigned hellos;
        int unsigned shape;
        int unsigned sid_len;
        int unsigned comp_len;
        int unsigned trailing;
        int unsigned cut;
        int unsigned name_start;
        int unsigned noise_len;
        logic [15:0] suites_len;
        logic [15:0] ext_type;
        logic [15:0] name_len;

        sb = new(BUFFER_LIMIT);
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every record kind, byte extremes, a non-hello handshake and
        // a ClientHello cut before its session id.
        single_bytes = '{CT_HANDSHAKE, CT_CHANGE_CIPHER, CT_APP_DATA, 8'h00, 8'hFF};
        foreach (single_bytes[i]) begin
            buffer_bytes = '{single_bytes[i]};
            send_buffer();
        end
        buffer_bytes = '{CT_CHANGE_CIPHER, 8'hFF, 8'h00};
        send_buffer();
        buffer_bytes = '{CT_HANDSHAKE, 8'h03, 8'h03, 8'h00, 8'h10, 8'h02, 8'hAA};
        send_buffer();
        buffer_bytes = '{CT_HANDSHAKE, 8'h00, 8'h00, 8'h00, 8'h00, HS_CLIENT_HELLO,
                         8'h55, 8'hFF};
        send_buffer();

        // Back pressure: the receiver holds off while a long name streams in,
        // then the sender waits for the block to drain.
        steady_flow      = 1'b1;
        hold_off_request = 1'b1;
        build_hello(2, 16'd4, 1, 16'h0000, 16'd40, 0);
        send_buffer();
        wait_for_results();
        steady_flow = 1'b0;

        // Random buffers: ClientHello records of set shapes first, then a free mix
        // with noise buffers.
        random_start = bytes_sent;
        hellos       = 0;
        while (bytes_sent - random_start < RANDOM_ITEMS || sb.verdicts < MIN_VERDICTS) begin
            steady_flow = ($urandom_range(0, 9) == 0);
            if (hellos < NUM_SHAPES || $urandom_range(0, 99) < 45) begin
                shape      = (hellos < NUM_SHAPES) ? hellos : NUM_SHAPES;
                sid_len    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32) : 0;
                suites_len = 16'(2 * $urandom_range(0, 8));
                comp_len   = $urandom_range(0, 2);
                ext_type   = 16'h0000;
                name_len   = 16'($urandom_range(1, 24));
                trailing   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                cut        = 0;
                case (shape)
                    // Last name byte is also the final byte of the buffer.
                    0: trailing = 0;
                    1: name_len = '0;
                    2: ext_type = other_extension();
                    3: begin
                        name_len = 16'($urandom_range(2, 24));
                        trailing = 0;
                    end
                    4: ;
                    5: trailing = $urandom_range(1, 6);
                    // Suites and name lengths with a high byte; the name is cut short.
                    6: begin
                        sid_len    = 32;
                        suites_len = 16'h0100;
                        comp_len   = 2;
                        name_len   = 16'h0120;
                    end
                    default: begin
                        if ($urandom_range(0, 9) == 0) ext_type = other_extension();
                        if ($urandom_range(0, 9) == 0) name_len = '0;
                    end
                endcase
                build_hello(sid_len, suites_len, comp_len, ext_type, name_len, trailing);
                name_start = HELLO_HEADER + sid_len + suites_len + comp_len;
                case (shape)
                    3: cut = name_start + $urandom_range(1, name_len - 1);
                    4: cut = $urandom_range(1, name_start);
                    6: cut = name_start + 8;
                    NUM_SHAPES: begin
                        if ($urandom_range(0, 4) == 0) begin
                            cut = $urandom_range(1, buffer_bytes.size());
                        end
                    end
                    default: ;
                endcase
                if (cut != 0) begin
                    while (buffer_bytes.size() > cut) void'(buffer_bytes.pop_back());
                end
                hellos++;
            end else begin
                noise_len = $urandom_range(1, 12);
                buffer_bytes.delete();
                case ($urandom_range(0, 3))
                    0: buffer_bytes.push_back(CT_HANDSHAKE);
                    1: buffer_bytes.push_back(CT_CHANGE_CIPHER);
                    2: buffer_bytes.push_back(CT_APP_DATA);
                    default: buffer_bytes.push_back(8'($urandom));
                endcase
                repeat (noise_len - 1) buffer_bytes.push_back(8'($urandom));
            end
            send_buffer();
            if ($urandom_range(0, 9) == 0) wait_for_results();
        end

        steady_flow = 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));
        end

        $display("Sent %0d buffers (%0d bytes); %0d server name characters predicted.",
                 buffers_sent, bytes_sent, sb.name_chars);
        $display("Verdicts: %0d in all, %0d ClientHello, %0d with a name, %0d complete.",
                 sb.verdicts, sb.hello_verdicts, sb.found_verdicts, sb.complete_verdicts);
        if (sb.failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
